### sv/oaht_pkg.sv
`timescale 1ns / 1ps

package oaht_pkg;

    localparam int TABLE_SLOTS = 128;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 32;
    localparam int FUNC_W      = 2;
    localparam int STAT_W      = 2;
    localparam int MARK_W      = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SEARCH = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_DELETE = 2'd2
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [MARK_W-1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_USED    = 2'd1,
        MARK_DELETED = 2'd2
    } mark_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic read;
        logic advance;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic concluded;
        logic out_free;
    } dp_stat_t;

endpackage

### sv/oaht_ctrl.sv
`timescale 1ns / 1ps

module oaht_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  oaht_pkg::dp_stat_t stat,
    output oaht_pkg::ctrl_cmd_t cmd
);
    import oaht_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next  = state_reg;
        ready_next  = ready_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                    ready_next = 1'b0;
                end
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (!stat.concluded) begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end else if (stat.out_free) begin
                    // hold here until the result register can take the result
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

### sv/oaht_datapath.sv
`timescale 1ns / 1ps

module oaht_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  oaht_pkg::ctrl_cmd_t            cmd,
    output oaht_pkg::dp_stat_t             stat,
    input  logic [oaht_pkg::FUNC_W-1:0]    s_func,
    input  logic [oaht_pkg::KEY_W-1:0]     s_key,
    input  logic signed [oaht_pkg::VAL_W-1:0] s_value_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [oaht_pkg::STAT_W-1:0]    m_status,
    output logic signed [oaht_pkg::VAL_W-1:0] m_value_out,
    output logic [oaht_pkg::SLOT_W-1:0]    m_slot_index
);
    import oaht_pkg::*;

    // Slot storage; marks of slots never written read as empty via valid bits
    logic [MARK_W-1:0] mark_mem [TABLE_SLOTS];
    logic [KEY_W-1:0]  key_mem  [TABLE_SLOTS];
    logic [VAL_W-1:0]  val_mem  [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] slot_valid_reg;

    logic [FUNC_W-1:0] func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic [SLOT_W-1:0] cnt_reg;

    logic [MARK_W-1:0] mark_rd_reg;
    logic              valid_rd_reg;
    logic [KEY_W-1:0]  key_rd_reg;
    logic [VAL_W-1:0]  val_rd_reg;

    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [SLOT_W-1:0] out_index_reg;

    logic [MARK_W-1:0] eff_mark;
    logic              is_last;
    logic              concluded;
    logic              found;
    logic [STAT_W-1:0] res_status;
    logic [VAL_W-1:0]  res_value;
    logic [SLOT_W-1:0] res_index;
    logic [SLOT_W-1:0] pos_inc;
    logic              do_insert;
    logic              do_delete;

    assign eff_mark = valid_rd_reg ? mark_rd_reg : MARK_EMPTY;
    assign is_last  = (cnt_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign pos_inc  = (pos_reg == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : pos_reg + 1'b1;

    always_comb begin
        concluded  = 1'b0;
        found      = 1'b0;
        res_status = ST_MISS;
        res_value  = '0;
        res_index  = '0;
        case (func_reg)
            FUNC_SEARCH, FUNC_DELETE: begin
                if (eff_mark == MARK_EMPTY) begin
                    concluded = 1'b1;
                end else if (eff_mark == MARK_USED && key_rd_reg == key_reg) begin
                    concluded = 1'b1;
                    found     = 1'b1;
                end else if (is_last) begin
                    concluded = 1'b1;
                end
                if (found) begin
                    res_status = ST_OK;
                    res_value  = val_rd_reg;
                    res_index  = pos_reg;
                end
            end
            FUNC_INSERT: begin
                if (eff_mark == MARK_EMPTY || eff_mark == MARK_DELETED) begin
                    concluded  = 1'b1;
                    found      = 1'b1;
                    res_status = ST_OK;
                    res_index  = pos_reg;
                end else if (is_last) begin
                    concluded  = 1'b1;
                    res_status = ST_FULL;
                end
            end
            default: begin
                concluded = 1'b1;
            end
        endcase
    end

    assign stat.concluded = concluded;
    assign stat.out_free  = !out_valid_reg || m_ready;

    assign do_insert = cmd.finish && found && (func_reg == FUNC_INSERT);
    assign do_delete = cmd.finish && found && (func_reg == FUNC_DELETE);

    // Request and probe registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            key_reg  <= s_key;
            val_reg  <= s_value_in;
            pos_reg  <= s_key[SLOT_W-1:0];  // home slot: key mod table size
            cnt_reg  <= '0;
        end else if (cmd.advance) begin
            pos_reg <= pos_inc;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Slot memories: one read and one write port, read data registered
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            mark_rd_reg <= mark_mem[pos_reg];
            key_rd_reg  <= key_mem[pos_reg];
            val_rd_reg  <= val_mem[pos_reg];
        end
        if (do_insert) begin
            mark_mem[pos_reg] <= MARK_USED;
            key_mem[pos_reg]  <= key_reg;
            val_mem[pos_reg]  <= val_reg;
        end else if (do_delete) begin
            mark_mem[pos_reg] <= MARK_DELETED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            valid_rd_reg   <= 1'b0;
        end else begin
            if (cmd.read) begin
                valid_rd_reg <= slot_valid_reg[pos_reg];
            end
            if (do_insert) begin
                slot_valid_reg[pos_reg] <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
            out_index_reg  <= res_index;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_value_out  = out_value_reg;
    assign m_slot_index = out_index_reg;

    a_finish_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!out_valid_reg || m_ready))
        else $error("result overwritten before transfer");

    a_bounded_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.advance |-> !is_last)
        else $error("probe ran past one full pass");

    a_miss_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != ST_OK) |->
            (out_value_reg == '0 && out_index_reg == '0))
        else $error("miss or full result carries data");

    a_write_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> slot_valid_reg[$past(pos_reg)])
        else $error("inserted slot not marked valid");

endmodule

### sv/open_addressing_hash_table_unit.sv
`timescale 1ns / 1ps
// Channel   Ports                                          Direction
// request   s_valid s_ready s_func s_key s_value_in         in
// result    m_valid m_ready m_status m_value_out m_slot_index out
//
// A probe reads the slot memory, then compares; 1 to 128 slots are probed.
// One request at a time; the next one is taken while the result waits.
// Reset marks every slot empty at once; no clearing pass.
// A stalled result holds the last probe step until the result register frees.

module open_addressing_hash_table_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [oaht_pkg::FUNC_W-1:0]       s_func,
    input  logic [oaht_pkg::KEY_W-1:0]        s_key,
    input  logic signed [oaht_pkg::VAL_W-1:0] s_value_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [oaht_pkg::STAT_W-1:0]       m_status,
    output logic signed [oaht_pkg::VAL_W-1:0] m_value_out,
    output logic [oaht_pkg::SLOT_W-1:0]       m_slot_index
);
    import oaht_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    oaht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    oaht_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_func       (s_func),
        .s_key        (s_key),
        .s_value_in   (s_value_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_value_out  (m_value_out),
        .m_slot_index (m_slot_index)
    );

endmodule

### sim/oaht_checker.sv
`timescale 1ns / 1ps

module oaht_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [oaht_pkg::FUNC_W-1:0]        s_func,
    input  logic [oaht_pkg::KEY_W-1:0]         s_key,
    input  logic signed [oaht_pkg::VAL_W-1:0]  s_value_in,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [oaht_pkg::STAT_W-1:0]        m_status,
    input  logic signed [oaht_pkg::VAL_W-1:0]  m_value_out,
    input  logic [oaht_pkg::SLOT_W-1:0]        m_slot_index,
    output int                                 outstanding,
    output int                                 mismatches,
    output int                                 full_answers
);
    import oaht_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] slot;
    } answer_t;

    mark_t            slot_state [TABLE_SLOTS];
    logic [KEY_W-1:0] slot_key   [TABLE_SLOTS];
    logic [VAL_W-1:0] slot_data  [TABLE_SLOTS];
    answer_t          answer_q   [$];
    int               bad_count  = 0;
    int               full_count = 0;

    // Walk the probe path for a live entry; stop at an empty slot or after one pass.
    function automatic int locate(input logic [KEY_W-1:0] k);
        int pos;
        int found;
        int n;
        pos   = int'({1'b0, k} % TABLE_SLOTS);
        found = -1;
        for (n = 0; n < TABLE_SLOTS; n++) begin
            if (slot_state[pos] == MARK_EMPTY)
                break;
            if (slot_state[pos] == MARK_USED && slot_key[pos] == k) begin
                found = pos;
                break;
            end
            pos = (pos + 1) % TABLE_SLOTS;
        end
        return found;
    endfunction

    function automatic answer_t apply_request(input logic [FUNC_W-1:0] f,
                                              input logic [KEY_W-1:0]  k,
                                              input logic [VAL_W-1:0]  v);
        answer_t a;
        int      spot;
        int      pos;
        int      n;
        a.status = ST_MISS;
        a.value  = '0;
        a.slot   = '0;
        case (f)
            FUNC_SEARCH, FUNC_DELETE: begin
                spot = locate(k);
                if (spot >= 0) begin
                    a.status = ST_OK;
                    a.value  = slot_data[spot];
                    a.slot   = spot[SLOT_W-1:0];
                    if (f == FUNC_DELETE)
                        slot_state[spot] = MARK_DELETED;
                end
            end
            FUNC_INSERT: begin
                spot = -1;
                pos  = int'({1'b0, k} % TABLE_SLOTS);
                // Take the first empty or tombstoned slot, no duplicate check.
                for (n = 0; n < TABLE_SLOTS && spot < 0; n++) begin
                    if (slot_state[pos] == MARK_EMPTY || slot_state[pos] == MARK_DELETED)
                        spot = pos;
                    else
                        pos = (pos + 1) % TABLE_SLOTS;
                end
                if (spot >= 0) begin
                    slot_state[spot] = MARK_USED;
                    slot_key[spot]   = k;
                    slot_data[spot]  = v;
                    a.status         = ST_OK;
                    a.slot           = spot[SLOT_W-1:0];
                end else begin
                    a.status = ST_FULL;
                end
            end
            default: begin
            end
        endcase
        return a;
    endfunction

    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        if (!aresetn) begin
            foreach (slot_state[i])
                slot_state[i] = MARK_EMPTY;
            answer_q.delete();
        end else begin
            // Retire the result first: it always belongs to an earlier request.
            if (m_valid === 1'b1 && m_ready) begin
                got.status = m_status;
                got.value  = m_value_out;
                got.slot   = m_slot_index;
                if (m_status == ST_FULL)
                    full_count++;
                if (answer_q.size() == 0) begin
                    if (bad_count < 10)
                        $display("%0t: unexpected transfer status=%0d value=%h slot=%0d",
                                 $realtime, got.status, got.value, got.slot);
                    bad_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (got.status !== want.status || got.value !== want.value ||
                        got.slot !== want.slot) begin
                        if (bad_count < 10)
                            $display("%0t: exp st=%0d val=%h slot=%0d, got st=%0d val=%h slot=%0d",
                                     $realtime, want.status, want.value, want.slot,
                                     got.status, got.value, got.slot);
                        bad_count++;
                    end
                end
            end
            if (s_valid && s_ready === 1'b1)
                answer_q.push_back(apply_request(s_func, s_key, s_value_in));
        end
        outstanding  <= answer_q.size();
        mismatches   <= bad_count;
        full_answers <= full_count;
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import oaht_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int                POOL_SIZE   = 48;

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic [FUNC_W-1:0]       s_func      = '0;
    logic [KEY_W-1:0]        s_key       = '0;
    logic signed [VAL_W-1:0] s_value_in  = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic [STAT_W-1:0]       m_status;
    logic signed [VAL_W-1:0] m_value_out;
    logic [SLOT_W-1:0]       m_slot_index;

    int               outstanding;
    int               mismatches;
    int               full_answers;
    bit               steady = 1'b0;
    int               op_count [4];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    open_addressing_hash_table_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_key        (s_key),
        .s_value_in   (s_value_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_value_out  (m_value_out),
        .m_slot_index (m_slot_index)
    );

    oaht_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_key        (s_key),
        .s_value_in   (s_value_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_value_out  (m_value_out),
        .m_slot_index (m_slot_index),
        .outstanding  (outstanding),
        .mismatches   (mismatches),
        .full_answers (full_answers)
    );

    // Call at a rising edge; returns at the edge of the transfer.
    task automatic offer(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                         input logic signed [VAL_W-1:0] v);
        while (!steady && $urandom_range(0, 99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= f;
        s_key      <= k;
        s_value_in <= v;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        op_count[f]++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // Mostly keys that collide on a few home slots, some of them wrapping past the top.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 15)
            return KEY_W'($urandom);
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic run_mix(input int count, input int ins_pct, input int del_pct,
                           input int odd_pct);
        int                roll;
        logic [FUNC_W-1:0] f;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                f = FUNC_INSERT;
            else if (roll < ins_pct + del_pct)
                f = FUNC_DELETE;
            else if (roll < ins_pct + del_pct + odd_pct)
                f = FUNC_UNUSED;
            else
                f = FUNC_SEARCH;
            offer(f, pick_key(), $urandom);
        end
    endtask

    // Result side: random stalls, one long hold-off to back up the request side.
    initial begin
        int taken;
        int hold;
        bit held;
        taken = 0;
        hold  = 0;
        held  = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready)
                taken++;
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (!held && taken >= 60) begin
                held = 1'b1;
                hold = 400;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 24);
            end
        end
    end

    initial begin
        logic [31:0] upper;
        int          pos;
        for (int i = 0; i < POOL_SIZE; i++) begin
            upper       = $urandom;
            pos         = i % 6;
            key_pool[i] = {upper[KEY_W-SLOT_W-1:0],
                           (pos < 4) ? SLOT_W'(126 + pos) : SLOT_W'(36 + pos)};
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer(FUNC_SEARCH, 31'd0, 32'sd0);
        offer(FUNC_DELETE, 31'd0, 32'sd0);
        offer(FUNC_INSERT, 31'd0, 32'sh7FFFFFFF);
        offer(FUNC_INSERT, 31'd127, 32'sh80000000);
        offer(FUNC_INSERT, 31'h7FFFFFFF, -32'sd1);
        offer(FUNC_INSERT, 31'd255, 32'sd100);
        offer(FUNC_SEARCH, 31'h7FFFFFFF, 32'sd0);
        offer(FUNC_SEARCH, 31'd255, 32'sd0);
        offer(FUNC_INSERT, 31'd127, 32'sd5);
        offer(FUNC_SEARCH, 31'd127, 32'sd0);
        offer(FUNC_DELETE, 31'd127, 32'sd0);
        offer(FUNC_SEARCH, 31'd127, 32'sd0);
        offer(FUNC_INSERT, 31'd383, 32'sd7);
        offer(FUNC_SEARCH, 31'd511, 32'sd0);
        offer(FUNC_UNUSED, 31'd0, 32'sd9);
        offer(FUNC_SEARCH, 31'd0, 32'sd0);
        offer(FUNC_DELETE, 31'd0, 32'sd0);
        offer(FUNC_DELETE, 31'd0, 32'sd0);
        offer(FUNC_INSERT, 31'd128, 32'sd1);
        offer(FUNC_SEARCH, 31'h7FFFFFFF, 32'sd0);
        offer(FUNC_UNUSED, 31'h7FFFFFFF, -32'sd1);

        run_mix(150, 40, 20, 5);
        steady <= 1'b1;
        run_mix(130, 40, 20, 5);
        steady <= 1'b0;
        drain();

        // Overfill: every slot ends up live or tombstoned, so misses take a full pass.
        repeat (150) offer(FUNC_INSERT, KEY_W'($urandom), $urandom);
        run_mix(60, 30, 25, 5);
        run_mix(370, 25, 40, 4);

        drain();
        repeat (20) @(posedge aclk);
        $display("Covered %0d requests: %0d search, %0d insert, %0d delete, %0d unused code",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("Table driven past capacity with wrap-around probing; %0d inserts refused as full",
                 full_answers);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Timeout with %0d results still outstanding", outstanding);
        $display("TEST FAILED");
        $finish;
    end

endmodule
